@@ sv/cicd_pkg.sv @@
// ----------------------------------------------------------------------------
// cicd_pkg
// types and constants shared by the cloud-in-cell current deposition block
// ----------------------------------------------------------------------------
package cicd_pkg;

  localparam int SHARE_W = 39;  // magnitude of one node share
  localparam int ADDR_W  = 20;  // widest node address the grid parameters allow
  localparam int OUT_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

  typedef enum logic [1:0] {
    MODE_DEPOSIT = 2'd0,
    MODE_READ    = 2'd1,
    MODE_CLEAR   = 2'd2
  } cicd_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_X   = 3'd0,
    CFG_INV_Y   = 3'd1,
    CFG_Q_ION   = 3'd2,
    CFG_Q_ELEC  = 3'd3,
    CFG_X_USED  = 3'd4,
    CFG_Y_USED  = 3'd5
  } cicd_cfg_idx_e;

  typedef enum logic [1:0] {
    OP_DEPOSIT,
    OP_READ,
    OP_CLEAR
  } cicd_op_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SCALE,
    F_DIV,
    F_MUL,
    F_WX,
    F_SHARE,
    F_PUSH
  } cicd_front_state_e;

  typedef enum logic [2:0] {
    B_CLR,
    B_IDLE,
    B_DEP,
    B_RD,
    B_RDATA
  } cicd_back_state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic               species;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        lorentz_factor;
    logic [5:0]         node_x;
    logic [5:0]         node_y;
  } cicd_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] current_x;
    logic signed [OUT_W-1:0] current_y;
    logic signed [OUT_W-1:0] current_z;
  } cicd_out_t;

  typedef struct packed {
    logic [31:0]        inv_x;
    logic [31:0]        inv_y;
    logic signed [31:0] q_ion;
    logic signed [31:0] q_elec;
    logic [6:0]         x_used;
    logic [6:0]         y_used;
  } cicd_cfg_t;

  // node order: index 2*a+b, a selects upper x node, b upper y node
  typedef struct packed {
    cicd_op_e                             op;
    logic [3:0][ADDR_W-1:0]               addr;
    logic [3:0][2:0][SHARE_W-1:0]         share;
    logic [2:0]                           neg;
    logic                                 zero;
  } cicd_cmd_t;

  typedef struct packed {
    logic init_busy;
  } cicd_stat_t;

endpackage

@@ sv/cicd_ram.sv @@
// ----------------------------------------------------------------------------
// cicd_ram
// generic one write port, one read port ram with registered read
// ----------------------------------------------------------------------------
module cicd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/cicd_front.sv @@
// ----------------------------------------------------------------------------
// cicd_front
// takes input words; reads and clears go to the back end as commands directly;
// for a deposit it scales positions, divides charge by gamma and forms the
// twelve node shares of a particle, handed on only if it lies in the used grid
module cicd_front #(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cicd_pkg::cicd_cfg_t cfg_i,
  input  logic                hold_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cicd_pkg::cicd_in_t  in_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cicd_pkg::cicd_cmd_t cmd_o
);
  import cicd_pkg::*;

  localparam int XCW = $clog2(GRID_X + 1);
  localparam int YCW = $clog2(GRID_Y + 1);
  localparam int XW  = $clog2(GRID_X);
  localparam int YW  = $clog2(GRID_Y);

  cicd_front_state_e state_q, state_d;

  cicd_in_t          item_q;
  logic [31:0]       ix_q, iy_q;
  logic [15:0]       fx_q, fy_q;
  logic [31:0]       rem_q, nq_q, g_q;
  logic [4:0]        cnt_q;
  logic              qneg_q;
  logic [2:0][SHARE_W-1:0]      jm_q;
  logic [2:0][1:0][SHARE_W-1:0] t_q;
  cicd_cmd_t         cmd_q;

  logic [XCW-1:0] nx;
  logic [YCW-1:0] ny;
  logic           accept;
  logic signed [31:0] q_sel;
  logic [31:0]    q_abs;
  logic [63:0]    sx, sy;
  logic [32:0]    rem_sh;
  logic           rem_ge;
  logic [2:0][31:0] v_abs;
  logic [2:0][63:0] jprod;
  logic [16:0]    wx [2];
  logic [16:0]    wy [2];
  logic           drop;
  logic [XCW-1:0] ix2;
  logic [YCW-1:0] iy2;
  logic [ADDR_W-1:0] ax0, ax1, rd_addr;

  // used sizes clamped to two and to the grid
  always_comb begin
    if ({25'd0, cfg_i.x_used} < 32'd2) nx = XCW'(2);
    else if ({25'd0, cfg_i.x_used} > 32'(GRID_X)) nx = XCW'(GRID_X);
    else nx = XCW'(cfg_i.x_used);
    if ({25'd0, cfg_i.y_used} < 32'd2) ny = YCW'(2);
    else if ({25'd0, cfg_i.y_used} > 32'(GRID_Y)) ny = YCW'(GRID_Y);
    else ny = YCW'(cfg_i.y_used);
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != F_IDLE) || hold_i;
  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o       = cmd_q;

  assign q_sel = item_q.species ? cfg_i.q_elec : cfg_i.q_ion;
  assign q_abs = q_sel[31] ? 32'(-q_sel) : 32'(q_sel);
  assign sx    = item_q.pos_x * cfg_i.inv_x;
  assign sy    = item_q.pos_y * cfg_i.inv_y;

  assign rem_sh = {rem_q, nq_q[31]};
  assign rem_ge = rem_sh >= {1'b0, g_q};

  assign v_abs[0] = item_q.vel_x[31] ? 32'(-item_q.vel_x) : 32'(item_q.vel_x);
  assign v_abs[1] = item_q.vel_y[31] ? 32'(-item_q.vel_y) : 32'(item_q.vel_y);
  assign v_abs[2] = item_q.vel_z[31] ? 32'(-item_q.vel_z) : 32'(item_q.vel_z);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      jprod[c] = nq_q * v_abs[c];
    end
  end

  assign wx[0] = 17'h10000 - {1'b0, fx_q};
  assign wx[1] = {1'b0, fx_q};
  assign wy[0] = 17'h10000 - {1'b0, fy_q};
  assign wy[1] = {1'b0, fy_q};

  assign drop = (ix_q >= 32'(nx)) || (iy_q >= 32'(ny));
  assign ix2  = (XCW'(ix_q[XW-1:0]) + XCW'(1) == nx) ? '0 : XCW'(ix_q[XW-1:0]) + XCW'(1);
  assign iy2  = (YCW'(iy_q[YW-1:0]) + YCW'(1) == ny) ? '0 : YCW'(iy_q[YW-1:0]) + YCW'(1);
  assign ax0  = ADDR_W'(ix_q[XW-1:0]) * ADDR_W'(GRID_Y);
  assign ax1  = ADDR_W'(ix2) * ADDR_W'(GRID_Y);
  assign rd_addr = ADDR_W'(in_i.node_x) * ADDR_W'(GRID_Y) + ADDR_W'(in_i.node_y);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            MODE_DEPOSIT: state_d = F_SCALE;
            MODE_READ:    state_d = F_PUSH;
            MODE_CLEAR:   state_d = F_PUSH;
            default:      state_d = F_IDLE;
          endcase
        end
      end
      F_SCALE: state_d = F_DIV;
      F_DIV:   if (cnt_q == 5'd31) state_d = F_MUL;
      F_MUL:   state_d = drop ? F_IDLE : F_WX;
      F_WX:    state_d = F_SHARE;
      F_SHARE: state_d = F_PUSH;
      F_PUSH:  if (cmd_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          item_q      <= in_i;
          cmd_q.op    <= (in_i.mode == MODE_READ) ? OP_READ : OP_CLEAR;
          cmd_q.addr[0] <= rd_addr;
          cmd_q.zero  <= ({26'd0, in_i.node_x} >= 32'(nx)) ||
                         ({26'd0, in_i.node_y} >= 32'(ny));
        end
      end
      F_SCALE: begin
        ix_q   <= sx[63:32];
        fx_q   <= sx[31:16];
        iy_q   <= sy[63:32];
        fy_q   <= sy[31:16];
        g_q    <= (item_q.lorentz_factor < ONE_Q24) ? ONE_Q24 : item_q.lorentz_factor;
        rem_q  <= {8'd0, q_abs[31:8]};
        nq_q   <= {q_abs[7:0], 24'd0};
        qneg_q <= q_sel[31];
        cnt_q  <= '0;
      end
      F_DIV: begin
        // one quotient bit a cycle
        rem_q <= rem_ge ? 32'(rem_sh - {1'b0, g_q}) : rem_sh[31:0];
        nq_q  <= {nq_q[30:0], rem_ge};
        cnt_q <= cnt_q + 5'd1;
      end
      F_MUL: begin
        for (int c = 0; c < 3; c++) begin
          jm_q[c] <= jprod[c][62:24];
        end
        cmd_q.neg[0] <= qneg_q ^ item_q.vel_x[31];
        cmd_q.neg[1] <= qneg_q ^ item_q.vel_y[31];
        cmd_q.neg[2] <= qneg_q ^ item_q.vel_z[31];
        cmd_q.op      <= OP_DEPOSIT;
        cmd_q.zero    <= 1'b0;
        cmd_q.addr[0] <= ax0 + ADDR_W'(iy_q[YW-1:0]);
        cmd_q.addr[1] <= ax0 + ADDR_W'(iy2);
        cmd_q.addr[2] <= ax1 + ADDR_W'(iy_q[YW-1:0]);
        cmd_q.addr[3] <= ax1 + ADDR_W'(iy2);
      end
      F_WX: begin
        for (int c = 0; c < 3; c++) begin
          for (int a = 0; a < 2; a++) begin
            t_q[c][a] <= 39'((56'(jm_q[c]) * 56'(wx[a])) >> 16);
          end
        end
      end
      F_SHARE: begin
        for (int c = 0; c < 3; c++) begin
          for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
              cmd_q.share[2*a+b][c] <= 39'((56'(t_q[c][a]) * 56'(wy[b])) >> 16);
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/cicd_queue.sv @@
// ----------------------------------------------------------------------------
// cicd_queue
// two-entry command queue between front and back end
// ----------------------------------------------------------------------------
module cicd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  cicd_pkg::cicd_cmd_t push_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output cicd_pkg::cicd_cmd_t pop_o
);
  import cicd_pkg::*;

  cicd_cmd_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_o        = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_i;
  end

endmodule

@@ sv/cicd_back.sv @@
// ----------------------------------------------------------------------------
// cicd_back
// owns the three current grids: read-modify-write of deposits, node reads
// and clearing sweeps
// ----------------------------------------------------------------------------
module cicd_back #(
  parameter int GRID_X    = 64,
  parameter int GRID_Y    = 64,
  parameter int ACC_WIDTH = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cicd_pkg::cicd_cmd_t  cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cicd_pkg::cicd_out_t  out_o,
  output cicd_pkg::cicd_stat_t stat_o
);
  import cicd_pkg::*;

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUMW  = ((ACC_WIDTH > SHARE_W) ? ACC_WIDTH : SHARE_W) + 2;
  localparam int OW    = ((ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W) + 1;

  cicd_back_state_e state_q, state_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             init_q, init_d;
  logic             out_valid_q, out_valid_d;
  cicd_cmd_t        cmd_q;
  cicd_out_t        out_q;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [1:0]           wk;
  logic [ACC_WIDTH-1:0] wdata [3];
  logic [ACC_WIDTH-1:0] rdata [3];
  logic                 drain, load_out;

  function automatic logic [ACC_WIDTH-1:0] sat_add(logic [ACC_WIDTH-1:0] acc,
                                                   logic [SHARE_W-1:0] m, logic neg);
    logic signed [SUMW-1:0] a, s, maxv, minv;
    a    = SUMW'(signed'(acc));
    maxv = signed'({{(SUMW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}});
    minv = ~maxv;
    s    = neg ? a - signed'(SUMW'(m)) : a + signed'(SUMW'(m));
    if (s > maxv) s = maxv;
    if (s < minv) s = minv;
    return s[ACC_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] out_sat(logic [ACC_WIDTH-1:0] acc);
    logic signed [OW-1:0] a, maxv, minv;
    a    = OW'(signed'(acc));
    maxv = signed'({{(OW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
    minv = ~maxv;
    if (a > maxv) a = maxv;
    if (a < minv) a = minv;
    return a[OUT_W-1:0];
  endfunction

  for (genvar c = 0; c < 3; c++) begin : g_grid
    cicd_ram #(.WIDTH(ACC_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata[c]),
      .raddr_i (raddr),
      .rdata_o (rdata[c])
    );
    assign wdata[c] = (state_q == B_CLR) ? '0 :
                      sat_add(rdata[c], cmd_q.share[wk][c], cmd_q.neg[c]);
  end

  assign wk          = 2'(cnt_q - (AW+1)'(1));
  assign drain       = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign stat_o.init_busy = init_q;
  assign cmd_ready_o = (state_q == B_IDLE);
  assign load_out    = (state_q == B_RDATA);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    init_d      = init_q;
    out_valid_d = out_valid_q && !drain;
    we          = 1'b0;
    waddr       = cnt_q[AW-1:0];
    raddr       = cmd_q.addr[cnt_q[1:0]][AW-1:0];
    case (state_q)
      B_CLR: begin
        we    = 1'b1;
        cnt_d = cnt_q + (AW+1)'(1);
        if (cnt_q == (AW+1)'(DEPTH - 1)) begin
          state_d = B_IDLE;
          init_d  = 1'b0;
        end
      end
      B_IDLE: begin
        cnt_d = '0;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_DEPOSIT: state_d = B_DEP;
            OP_READ:    state_d = B_RD;
            OP_CLEAR:   state_d = B_CLR;
            default:    state_d = B_IDLE;
          endcase
        end
      end
      B_DEP: begin
        // read node k while writing back node k-1
        waddr = cmd_q.addr[wk][AW-1:0];
        we    = (cnt_q != '0);
        cnt_d = cnt_q + (AW+1)'(1);
        if (cnt_q == (AW+1)'(4)) state_d = B_IDLE;
      end
      B_RD: begin
        raddr = cmd_q.addr[0][AW-1:0];
        if (!out_valid_q) state_d = B_RDATA;
      end
      B_RDATA: begin
        out_valid_d = 1'b1;
        state_d     = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      cnt_q       <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) cmd_q <= cmd_i;
    if (load_out) begin
      out_q.current_x <= cmd_q.zero ? '0 : out_sat(rdata[0]);
      out_q.current_y <= cmd_q.zero ? '0 : out_sat(rdata[1]);
      out_q.current_z <= cmd_q.zero ? '0 : out_sat(rdata[2]);
    end
  end

endmodule

@@ sv/cic_current_deposit_2d.sv @@
// ----------------------------------------------------------------------------
// cic_current_deposit_2d
// deposit: the front end scales, runs the 32-step charge/gamma divider and
//   forms the shares before it takes another word; the back end writes the
//   four nodes by read-modify-write; read: a registered result word; clear:
//   one node per cycle over GRID_X*GRID_Y nodes
// reset: a clearing pass zeroes all GRID_X*GRID_Y nodes, input stalled
// ----------------------------------------------------------------------------
module cic_current_deposit_2d #(
  parameter int GRID_X    = 64,
  parameter int GRID_Y    = 64,
  parameter int ACC_WIDTH = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cicd_pkg::cicd_in_t              in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cicd_pkg::cicd_out_t             out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cicd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import cicd_pkg::*;

  cicd_cfg_t  cfg_q;
  cicd_stat_t stat;
  cicd_cmd_t  f_cmd, b_cmd;
  logic       f_valid, f_ready, b_valid, b_ready;

  // registers may be written at any time; the block is idle by contract
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_x  <= 32'h0001_0000;
      cfg_q.inv_y  <= 32'h0001_0000;
      cfg_q.q_ion  <= 32'sh0100_0000;
      cfg_q.q_elec <= -32'sh0100_0000;
      cfg_q.x_used <= 7'd64;
      cfg_q.y_used <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_INV_X:  cfg_q.inv_x  <= cfg_data_i;
        CFG_INV_Y:  cfg_q.inv_y  <= cfg_data_i;
        CFG_Q_ION:  cfg_q.q_ion  <= cfg_data_i;
        CFG_Q_ELEC: cfg_q.q_elec <= cfg_data_i;
        CFG_X_USED: cfg_q.x_used <= cfg_data_i[6:0];
        CFG_Y_USED: cfg_q.y_used <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // front end: accepts words, builds commands
  cicd_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .hold_i      (stat.init_busy),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  // short queue so front and back stall independently
  cicd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_i       (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_o        (b_cmd)
  );

  // back end: grid memories and result register
  cicd_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .stat_o      (stat)
  );

`ifndef SYNTH
  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.init_busy |-> in_stall_o)
    else $error("input taken during clearing pass");

  a_push_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && f_ready) |=> !f_valid)
    else $error("front end offered a command twice");
`endif

endmodule

@@ tb/cic_current_deposit_2d_tb.sv @@
// ----------------------------------------------------------------------------
// cic_current_deposit_2d_tb
// self-checking bench for the cloud-in-cell current deposition block: a
// directed table then random particle bursts, node reads and clears, checked
// word by word against an in-bench model of the grids, under several configurations
// ----------------------------------------------------------------------------
module cic_current_deposit_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cicd_pkg::*;

  localparam int GX = 64;
  localparam int GY = 64;
  localparam int NODES = GX * GY;
  localparam logic signed [63:0] ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = -ACC_MAX - 64'sd1;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES = 3 * NODES + 200;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  cicd_in_t in_word;
  cicd_out_t out_word;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  cic_current_deposit_2d DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // model state
  logic signed [63:0] grid_jx [NODES];
  logic signed [63:0] grid_jy [NODES];
  logic signed [63:0] grid_jz [NODES];
  logic [31:0] inv_x, inv_y;
  logic signed [31:0] q_ion, q_elec;
  logic [6:0] x_used, y_used;

  cicd_out_t pending_reads[$];
  int errors, n_items, n_reads, n_deposits, n_dropped, n_cfg;
  int send_idle_pct, recv_idle_pct;
  longint cycles;

  function automatic int used_nodes(logic [6:0] n, int top);
    if (n < 2) return 2;
    if (n > top) return top;
    return n;
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] acc,
                                                 logic [63:0] mag, logic neg);
    logic signed [63:0] m;
    m = mag;
    if (!neg) return (acc > ACC_MAX - m) ? ACC_MAX : acc + m;
    return (acc < ACC_MIN + m) ? ACC_MIN : acc - m;
  endfunction

  // bilinear cloud-in-cell deposit of one particle into the model grids
  task automatic deposit_particle(cicd_in_t w);
    int nx, ny, ix2, iy2, a, b, c;
    logic [63:0] sx, sy, ix, iy, fx, fy, g, qmag, qog, vmag, jmag, share;
    logic [63:0] wx [2];
    logic [63:0] wy [2];
    logic signed [31:0] q, v;
    int node [2][2];
    logic neg;
    nx = used_nodes(x_used, GX);
    ny = used_nodes(y_used, GY);
    sx = {32'd0, w.pos_x} * {32'd0, inv_x};
    sy = {32'd0, w.pos_y} * {32'd0, inv_y};
    ix = sx >> 32;
    iy = sy >> 32;
    fx = (sx >> 16) & 64'hFFFF;
    fy = (sy >> 16) & 64'hFFFF;
    if (ix >= nx || iy >= ny) begin
      n_dropped++;
      return;
    end
    ix2 = (ix + 1 == nx) ? 0 : int'(ix) + 1;
    iy2 = (iy + 1 == ny) ? 0 : int'(iy) + 1;
    g = w.lorentz_factor;
    if (g < ONE_Q24) g = ONE_Q24;
    q = w.species ? q_elec : q_ion;
    qmag = q < 0 ? -64'(q) : 64'(q);
    qog = (qmag << 24) / g;
    wx[0] = 65536 - fx; wx[1] = fx;
    wy[0] = 65536 - fy; wy[1] = fy;
    node[0][0] = ix * GY + iy;
    node[1][0] = ix2 * GY + iy;
    node[0][1] = ix * GY + iy2;
    node[1][1] = ix2 * GY + iy2;
    for (c = 0; c < 3; c++) begin
      v = (c == 0) ? w.vel_x : (c == 1) ? w.vel_y : w.vel_z;
      vmag = v < 0 ? -64'(v) : 64'(v);
      jmag = (qog * vmag) >> 24;
      neg = (q < 0) != (v < 0);
      for (a = 0; a < 2; a++)
        for (b = 0; b < 2; b++) begin
          share = (((jmag * wx[a]) >> 16) * wy[b]) >> 16;
          case (c)
            0: grid_jx[node[a][b]] = sat_add(grid_jx[node[a][b]], share, neg);
            1: grid_jy[node[a][b]] = sat_add(grid_jy[node[a][b]], share, neg);
            default: grid_jz[node[a][b]] = sat_add(grid_jz[node[a][b]], share, neg);
          endcase
        end
    end
    n_deposits++;
  endtask

  task automatic clear_model();
    foreach (grid_jx[k]) begin
      grid_jx[k] = 0; grid_jy[k] = 0; grid_jz[k] = 0;
    end
  endtask

  // update the model for one accepted word, queueing a read's result
  task automatic model_word(cicd_in_t w);
    cicd_out_t r;
    int k;
    case (w.mode)
      MODE_DEPOSIT: deposit_particle(w);
      MODE_READ: begin
        if (w.node_x >= used_nodes(x_used, GX) || w.node_y >= used_nodes(y_used, GY)) begin
          r = '0;
        end else begin
          k = w.node_x * GY + w.node_y;
          r.current_x = grid_jx[k][47:0];
          r.current_y = grid_jy[k][47:0];
          r.current_z = grid_jz[k][47:0];
        end
        pending_reads.push_back(r);
        n_reads++;
      end
      MODE_CLEAR: clear_model();
      default: ;
    endcase
  endtask

  // result side: random stall, compare every word against the oldest read
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reads.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_word);
          errors++;
        end else begin
          cicd_out_t e;
          e = pending_reads.pop_front();
          if (out_word.current_x !== e.current_x) begin
            $display("%0t: current_x expected %h actual %h", $time, e.current_x,
                     out_word.current_x);
            errors++;
          end
          if (out_word.current_y !== e.current_y) begin
            $display("%0t: current_y expected %h actual %h", $time, e.current_y,
                     out_word.current_y);
            errors++;
          end
          if (out_word.current_z !== e.current_z) begin
            $display("%0t: current_z expected %h actual %h", $time, e.current_z,
                     out_word.current_z);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // send one word; the sender may idle first, then holds until accepted
  // valid stays up on return so the next word can follow at the same edge
  task automatic send_word(cicd_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_word(w);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // register writes happen only with the block idle, after any clear has run
  task automatic write_reg(cicd_cfg_idx_e idx, logic [31:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      CFG_INV_X: inv_x = val;
      CFG_INV_Y: inv_y = val;
      CFG_Q_ION: q_ion = val;
      CFG_Q_ELEC: q_elec = val;
      CFG_X_USED: x_used = val[6:0];
      CFG_Y_USED: y_used = val[6:0];
      default: ;
    endcase
  endtask

  function automatic cicd_in_t make_word(logic [1:0] mode, logic sp, logic [31:0] px,
                                         logic [31:0] py, logic [31:0] vx, logic [31:0] vy,
                                         logic [31:0] vz, logic [31:0] g, logic [5:0] nx,
                                         logic [5:0] ny);
    cicd_in_t w;
    w.mode = mode; w.species = sp; w.pos_x = px; w.pos_y = py;
    w.vel_x = vx; w.vel_y = vy; w.vel_z = vz; w.lorentz_factor = g;
    w.node_x = nx; w.node_y = ny;
    return w;
  endfunction

  function automatic logic [31:0] rand_pos(int n);
    // mostly inside the used grid at unit cell width, sometimes anywhere
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(n * 65536 - 1);
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // random phase: a random mix of deposits, node reads, rare clears and unknown modes
  task automatic random_phase(int count);
    cicd_in_t w;
    int nx, ny, r;
    logic [5:0] rx, ry;
    nx = used_nodes(x_used, GX);
    ny = used_nodes(y_used, GY);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      rx = (r % 7 == 0) ? $urandom : $urandom_range(nx - 1);
      ry = (r % 5 == 0) ? $urandom : $urandom_range(ny - 1);
      if (r < 55)
        w = make_word(MODE_DEPOSIT, $urandom, rand_pos(nx), rand_pos(ny), rand_vel(),
                      rand_vel(), rand_vel(),
                      ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0800_0000,
                                                                          32'h0100_0000 - 0),
                      $urandom, $urandom);
      else if (r < 97)
        w = make_word(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, rx, ry);
      else if (r < 98)
        w = make_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      else
        w = make_word(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      send_word(w);
    end
  endtask

  cicd_in_t directed [$];
  cicd_out_t directed_expect [$];
  logic directed_known [$];

  initial begin
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    errors = 0; n_items = 0; n_reads = 0; n_deposits = 0; n_dropped = 0; n_cfg = 0;
    cycles = 0;
    send_idle_pct = 25;
    recv_idle_pct = 84;
    inv_x = 32'd65536; inv_y = 32'd65536;
    q_ion = 32'sd16777216; q_elec = -32'sd16777216;
    x_used = 7'd64; y_used = 7'd64;
    clear_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: {word, known result, result is typed in}
    // reads after reset are zero
    directed.push_back(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 63, 63));
    // ion at node (0,0), unit velocity: full weight goes to node (0,0)
    directed.push_back(make_word(MODE_DEPOSIT, 0, 0, 0, 32'h0100_0000, 32'hFF00_0000,
                                 0, ONE_Q24, 0, 0));
    directed.push_back(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // half-cell fraction, electron, extreme velocities and gamma below one
    directed.push_back(make_word(MODE_DEPOSIT, 1, 32'h0000_8000, 32'h003F_8000,
                                 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0, 0));
    directed.push_back(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 63));
    directed.push_back(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    // top corner wraps to index 0 in both axes
    directed.push_back(make_word(MODE_DEPOSIT, 0, 32'h003F_FFFF, 32'h003F_FFFF,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'hFFFF_FFFF, 0, 0));
    directed.push_back(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 63, 0));
    // particle outside the grid is dropped
    directed.push_back(make_word(MODE_DEPOSIT, 0, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF,
                                 0, 0, ONE_Q24, 0, 0));
    directed.push_back(make_word(MODE_DEPOSIT, 1, 0, 32'h0040_0000, 32'h7FFF_FFFF,
                                 0, 0, ONE_Q24, 0, 0));
    // unknown mode does nothing
    directed.push_back(make_word(2'd3, 1, '1, '1, '1, '1, '1, '1, '1, '1));
    directed.push_back(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_word(MODE_READ, 1, '1, '1, '1, '1, '1, '1, 63, 63));
    // clear then read back zero
    directed.push_back(make_word(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_word(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed[k]) begin
      directed_known.push_back(k == 0 || k == 1 || k == 15);
      directed_expect.push_back('0);
    end

    for (i = 0; i < directed.size(); i++) begin
      send_word(directed[i]);
      // typed-in rows must agree with the model too
      if (directed_known[i] && pending_reads[$] !== directed_expect[i]) begin
        $display("%0t: directed row %0d expected %h actual %h", $time, i,
                 directed_expect[i], pending_reads[$]);
        errors++;
      end
    end

    // sender idles 25 of 100, receiver 84 of 100
    random_phase(130);
    // hold off until every read result has come back
    write_reg(CFG_X_USED, 7'd2);
    write_reg(CFG_Y_USED, 7'd0);
    write_reg(CFG_INV_X, 32'hFFFF_FFFF);
    write_reg(CFG_INV_Y, 32'd1);
    write_reg(CFG_Q_ION, 32'h7FFF_FFFF);
    write_reg(CFG_Q_ELEC, 32'h8000_0000);
    send_idle_pct = 84;
    recv_idle_pct = 25;
    random_phase(60);

    // saturating charges, unit cell width in x and zero scale in y, over a grid of 64 by 5 nodes
    write_reg(CFG_INV_X, 32'd65536);
    write_reg(CFG_INV_Y, 32'd0);
    write_reg(CFG_X_USED, 7'd127);
    write_reg(CFG_Y_USED, 7'd5);
    random_phase(80);

    // back to reset-like settings, x size in between, no idling
    write_reg(CFG_X_USED, 7'd37);
    write_reg(CFG_Y_USED, 7'd64);
    write_reg(CFG_INV_Y, 32'd65536);
    write_reg(CFG_Q_ION, 32'h0100_0000);
    write_reg(CFG_Q_ELEC, 32'hFF00_0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(230);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d words: %0d deposits, %0d dropped particles, %0d node reads",
             n_items, n_deposits, n_dropped, n_reads);
    $display("with %0d register writes across grid size and charge extremes", n_cfg);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
